// ===== rtl/dhmc_pkg.sv =====
// Shared types, constants and helpers of the desk height move controller.
`timescale 1ns / 1ps

package dhmc_pkg;

    localparam logic [31:0] KEEP_AWAKE_MS = 32'd5000;
    localparam logic [31:0] KEY_REPEAT_MS = 32'd100;
    localparam logic signed [16:0] DEADBAND = 17'sd5;

    typedef enum logic [1:0] {
        REQ_POLL   = 2'd0,
        REQ_HEIGHT = 2'd1,
        REQ_MOVE   = 2'd2,
        REQ_STOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        DRV_NONE = 2'd0,
        DRV_UP   = 2'd1,
        DRV_DOWN = 2'd2
    } drive_t;

    typedef enum logic [2:0] {
        RES_NONE    = 3'd0,
        RES_REACHED = 3'd1,
        RES_TIMEOUT = 3'd2,
        RES_NOFB    = 3'd3,
        RES_STALL   = 3'd4
    } result_code_t;

    typedef enum logic [2:0] {
        CFG_MIN_HEIGHT       = 3'd0,
        CFG_MAX_HEIGHT       = 3'd1,
        CFG_TARGET_TOLERANCE = 3'd2,
        CFG_STOP_MARGIN      = 3'd3,
        CFG_STALL_EPSILON    = 3'd4,
        CFG_STALL_TIMEOUT    = 3'd5,
        CFG_MOVE_TIMEOUT     = 3'd6,
        CFG_HEIGHT_STALE     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] min_height;
        logic [15:0] max_height;
        logic [11:0] target_tolerance;
        logic [11:0] stop_margin;
        logic [11:0] stall_epsilon;
        logic [31:0] stall_timeout;
        logic [31:0] move_timeout;
        logic [30:0] height_stale;
    } cfg_t;

    typedef struct packed {
        req_t        req_type;
        logic [31:0] now_ms;
        logic [15:0] height_reading;
        logic        reading_numeric;
        logic [15:0] target_height;
    } item_t;

    typedef struct packed {
        drive_t       drive;
        logic         send_frame;
        logic         wake_line;
        logic         target_active;
        result_code_t move_result;
        drive_t       motion;
        logic         height_valid;
    } result_t;

    function automatic logic span_over(input logic [31:0] now, input logic [31:0] since,
                                       input logic [31:0] span);
        logic [31:0] diff;
        diff = now - since;
        return diff >= span;
    endfunction

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/desk_height_move_controller.sv =====
// Top level of the desk height move controller.
`timescale 1ns / 1ps

// Usage:
// Requests enter on the s_ stream: s_tuser carries the request kind (poll, height report,
// move to target, stop), s_tdata the timestamp, height reading, numeric flag and target.
// Each request yields exactly one status word on the m_ stream: held keys, frame-sent
// flag, wake line, move-active flag, last move outcome, observed motion and height valid.
// Configuration registers are written through cfg_valid / cfg_index / cfg_data; cfg_ready
// is always high. Write them only while no request is in flight.
// A request accepted into the input register has its status word loaded into the result
// register once that register can advance, and shown on m_tvalid from then on.
// Throughput: one request per cycle while m_tready stays high, set by the state update,
// which is combinational between the input register and the result register.
// Reset (aresetn low, synchronous) clears all controller state, empties both registers
// and restores the configuration defaults.
// When the receiver stalls the result register holds; an empty input register still takes
// one more transaction, after which s_tready falls until m_tready returns.

module desk_height_move_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // now_ms, height_reading, reading_numeric, target_height
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // drive, send_frame, wake_line, target_active,
                                  // move_result, motion, height_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dhmc_pkg::cfg_t    cfg;
    dhmc_pkg::item_t   s_item;
    dhmc_pkg::item_t   item;
    dhmc_pkg::result_t result;
    dhmc_pkg::result_t m_result;
    logic              item_valid;
    logic              advance;
    logic              fire;

    always_comb begin
        s_item.req_type        = dhmc_pkg::req_t'(s_tuser);
        s_item.now_ms          = s_tdata[31:0];
        s_item.height_reading  = s_tdata[47:32];
        s_item.reading_numeric = s_tdata[48];
        s_item.target_height   = s_tdata[64:49];
    end

    assign fire = item_valid && advance;

    dhmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhmc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dhmc_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    dhmc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {5'd0, m_result.height_valid, m_result.motion, m_result.move_result,
                      m_result.target_active, m_result.wake_line, m_result.send_frame,
                      m_result.drive};

endmodule

// ===== rtl/dhmc_cfg_regs.sv =====
// Configuration register bank of the desk height move controller.
`timescale 1ns / 1ps

module dhmc_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output dhmc_pkg::cfg_t      cfg
);

    dhmc_pkg::cfg_t cfg_reg;
    dhmc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (dhmc_pkg::cfg_index_t'(cfg_index))
                dhmc_pkg::CFG_MIN_HEIGHT:       cfg_next.min_height = cfg_data[15:0];
                dhmc_pkg::CFG_MAX_HEIGHT:       cfg_next.max_height = cfg_data[15:0];
                dhmc_pkg::CFG_TARGET_TOLERANCE: cfg_next.target_tolerance = cfg_data[11:0];
                dhmc_pkg::CFG_STOP_MARGIN:      cfg_next.stop_margin = cfg_data[11:0];
                dhmc_pkg::CFG_STALL_EPSILON:    cfg_next.stall_epsilon = cfg_data[11:0];
                dhmc_pkg::CFG_STALL_TIMEOUT:    cfg_next.stall_timeout = cfg_data;
                dhmc_pkg::CFG_MOVE_TIMEOUT:     cfg_next.move_timeout = cfg_data;
                dhmc_pkg::CFG_HEIGHT_STALE:     cfg_next.height_stale = cfg_data[30:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_height       <= 16'd6200;
            cfg_reg.max_height       <= 16'd12800;
            cfg_reg.target_tolerance <= 12'd30;
            cfg_reg.stop_margin      <= 12'd100;
            cfg_reg.stall_epsilon    <= 12'd20;
            cfg_reg.stall_timeout    <= 32'd1500;
            cfg_reg.move_timeout     <= 32'd60000;
            cfg_reg.height_stale     <= 31'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/dhmc_in_stage.sv =====
// Input register of the desk height move controller.
`timescale 1ns / 1ps

module dhmc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dhmc_pkg::item_t     s_item,
    input  logic                advance,
    output logic                item_valid,
    output dhmc_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    dhmc_pkg::item_t item_reg;
    logic            load;

    assign s_ready    = !valid_reg || advance;
    assign load       = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/dhmc_step.sv =====
// Controller state and the per-transaction update of the desk height move controller.
`timescale 1ns / 1ps

module dhmc_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  dhmc_pkg::item_t     item,
    input  dhmc_pkg::cfg_t      cfg,
    output dhmc_pkg::result_t   result
);

    logic [15:0]            cur_height_reg, cur_height_next;
    logic                   cur_height_ok_reg, cur_height_ok_next;
    logic [31:0]            height_time_reg, height_time_next;
    dhmc_pkg::drive_t       motion_dir_reg, motion_dir_next;
    logic [15:0]            goal_height_reg, goal_height_next;
    logic                   moving_reg, moving_next;
    logic [31:0]            move_start_time_reg, move_start_time_next;
    logic [31:0]            stall_start_time_reg, stall_start_time_next;
    logic [15:0]            stall_ref_height_reg, stall_ref_height_next;
    dhmc_pkg::drive_t       held_drive_reg, held_drive_next;
    logic                   awake_flag_reg, awake_flag_next;
    logic [31:0]            awake_deadline_reg, awake_deadline_next;
    dhmc_pkg::drive_t       sent_drive_reg, sent_drive_next;
    logic [31:0]            last_send_time_reg, last_send_time_next;
    dhmc_pkg::result_code_t outcome_reg, outcome_next;

    logic                   send;
    logic                   finish;
    dhmc_pkg::result_code_t finish_code;
    logic [31:0]            wake_until;
    logic [31:0]            deadline_diff;
    logic [15:0]            goal_gap;
    logic signed [16:0]     hdelta;
    logic [15:0]            clamped;

    assign wake_until = item.now_ms + dhmc_pkg::KEEP_AWAKE_MS;

    always_comb begin
        cur_height_next       = cur_height_reg;
        cur_height_ok_next    = cur_height_ok_reg;
        height_time_next      = height_time_reg;
        motion_dir_next       = motion_dir_reg;
        goal_height_next      = goal_height_reg;
        moving_next           = moving_reg;
        move_start_time_next  = move_start_time_reg;
        stall_start_time_next = stall_start_time_reg;
        stall_ref_height_next = stall_ref_height_reg;
        held_drive_next       = held_drive_reg;
        awake_flag_next       = awake_flag_reg;
        awake_deadline_next   = awake_deadline_reg;
        sent_drive_next       = sent_drive_reg;
        last_send_time_next   = last_send_time_reg;
        outcome_next          = outcome_reg;
        send                  = 1'b0;
        finish                = 1'b0;
        finish_code           = dhmc_pkg::RES_NONE;
        goal_gap              = dhmc_pkg::abs_diff(goal_height_reg, cur_height_reg);
        hdelta                = $signed({1'b0, item.height_reading})
                                - $signed({1'b0, cur_height_reg});
        clamped               = item.target_height;
        deadline_diff         = 32'd0;

        unique case (item.req_type)
            dhmc_pkg::REQ_POLL: begin
                if (cur_height_ok_reg && dhmc_pkg::span_over(item.now_ms, height_time_reg,
                                                             {1'b0, cfg.height_stale})) begin
                    cur_height_ok_next = 1'b0;
                    motion_dir_next    = dhmc_pkg::DRV_NONE;
                end
                if (moving_reg) begin
                    awake_deadline_next = wake_until;
                    if (dhmc_pkg::span_over(item.now_ms, move_start_time_reg,
                                            cfg.move_timeout)) begin
                        finish      = 1'b1;
                        finish_code = dhmc_pkg::RES_TIMEOUT;
                    end else if (!cur_height_ok_next) begin
                        held_drive_next = dhmc_pkg::DRV_NONE;
                        if (dhmc_pkg::span_over(item.now_ms, move_start_time_reg,
                                                {cfg.height_stale, 1'b0})) begin
                            finish      = 1'b1;
                            finish_code = dhmc_pkg::RES_NOFB;
                        end
                    end else if (goal_gap <= {4'd0, cfg.target_tolerance}) begin
                        finish      = 1'b1;
                        finish_code = dhmc_pkg::RES_REACHED;
                    end else if (goal_gap <= {4'd0, cfg.stop_margin}) begin
                        held_drive_next = dhmc_pkg::DRV_NONE;
                        if (motion_dir_next == dhmc_pkg::DRV_NONE) begin
                            finish      = 1'b1;
                            finish_code = dhmc_pkg::RES_REACHED;
                        end
                    end else begin
                        held_drive_next = (goal_height_reg > cur_height_reg) ?
                                          dhmc_pkg::DRV_UP : dhmc_pkg::DRV_DOWN;
                        if (dhmc_pkg::abs_diff(cur_height_reg, stall_ref_height_reg)
                            > {4'd0, cfg.stall_epsilon}) begin
                            stall_ref_height_next = cur_height_reg;
                            stall_start_time_next = item.now_ms;
                        end else if (dhmc_pkg::span_over(item.now_ms, stall_start_time_reg,
                                                         cfg.stall_timeout)) begin
                            finish      = 1'b1;
                            finish_code = dhmc_pkg::RES_STALL;
                        end
                    end
                end
                if (finish) begin
                    moving_next         = 1'b0;
                    held_drive_next     = dhmc_pkg::DRV_NONE;
                    outcome_next        = finish_code;
                    awake_deadline_next = wake_until;
                end
                deadline_diff = item.now_ms - awake_deadline_next;
                if (awake_flag_reg && held_drive_next == dhmc_pkg::DRV_NONE && !moving_next
                    && !deadline_diff[31]) begin
                    awake_flag_next = 1'b0;
                end
                if (awake_flag_next && (held_drive_next != sent_drive_reg ||
                    dhmc_pkg::span_over(item.now_ms, last_send_time_reg,
                                        dhmc_pkg::KEY_REPEAT_MS))) begin
                    last_send_time_next = item.now_ms;
                    sent_drive_next     = held_drive_next;
                    send                = 1'b1;
                end
            end
            dhmc_pkg::REQ_HEIGHT: begin
                height_time_next = item.now_ms;
                if (item.reading_numeric) begin
                    cur_height_next    = item.height_reading;
                    cur_height_ok_next = 1'b1;
                    if (cur_height_ok_reg) begin
                        if (hdelta > dhmc_pkg::DEADBAND) begin
                            motion_dir_next = dhmc_pkg::DRV_UP;
                        end else if (hdelta < -dhmc_pkg::DEADBAND) begin
                            motion_dir_next = dhmc_pkg::DRV_DOWN;
                        end else begin
                            motion_dir_next = dhmc_pkg::DRV_NONE;
                        end
                    end
                end
            end
            dhmc_pkg::REQ_MOVE: begin
                if (clamped < cfg.min_height) begin
                    clamped = cfg.min_height;
                end
                if (clamped > cfg.max_height) begin
                    clamped = cfg.max_height;
                end
                if (!awake_flag_reg) begin
                    awake_flag_next     = 1'b1;
                    last_send_time_next = item.now_ms - dhmc_pkg::KEY_REPEAT_MS;
                end
                awake_deadline_next   = wake_until;
                goal_height_next      = clamped;
                moving_next           = 1'b1;
                outcome_next          = dhmc_pkg::RES_NONE;
                move_start_time_next  = item.now_ms;
                stall_start_time_next = item.now_ms;
                stall_ref_height_next = cur_height_reg;
                held_drive_next       = dhmc_pkg::DRV_NONE;
            end
            dhmc_pkg::REQ_STOP: begin
                held_drive_next     = dhmc_pkg::DRV_NONE;
                awake_deadline_next = wake_until;
                if (moving_reg) begin
                    moving_next  = 1'b0;
                    outcome_next = dhmc_pkg::RES_NONE;
                end
            end
            default: begin
                held_drive_next = held_drive_reg;
            end
        endcase
    end

    always_comb begin
        result.drive         = held_drive_next;
        result.send_frame    = send;
        result.wake_line     = awake_flag_next;
        result.target_active = moving_next;
        result.move_result   = outcome_next;
        result.motion        = motion_dir_next;
        result.height_valid  = cur_height_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_height_reg       <= 16'd0;
            cur_height_ok_reg    <= 1'b0;
            height_time_reg      <= 32'd0;
            motion_dir_reg       <= dhmc_pkg::DRV_NONE;
            goal_height_reg      <= 16'd0;
            moving_reg           <= 1'b0;
            move_start_time_reg  <= 32'd0;
            stall_start_time_reg <= 32'd0;
            stall_ref_height_reg <= 16'd0;
            held_drive_reg       <= dhmc_pkg::DRV_NONE;
            awake_flag_reg       <= 1'b0;
            awake_deadline_reg   <= 32'd0;
            sent_drive_reg       <= dhmc_pkg::DRV_NONE;
            last_send_time_reg   <= 32'd0;
            outcome_reg          <= dhmc_pkg::RES_NONE;
        end else if (fire) begin
            cur_height_reg       <= cur_height_next;
            cur_height_ok_reg    <= cur_height_ok_next;
            height_time_reg      <= height_time_next;
            motion_dir_reg       <= motion_dir_next;
            goal_height_reg      <= goal_height_next;
            moving_reg           <= moving_next;
            move_start_time_reg  <= move_start_time_next;
            stall_start_time_reg <= stall_start_time_next;
            stall_ref_height_reg <= stall_ref_height_next;
            held_drive_reg       <= held_drive_next;
            awake_flag_reg       <= awake_flag_next;
            awake_deadline_reg   <= awake_deadline_next;
            sent_drive_reg       <= sent_drive_next;
            last_send_time_reg   <= last_send_time_next;
            outcome_reg          <= outcome_next;
        end
    end

endmodule

// ===== rtl/dhmc_out_stage.sv =====
// Result register of the desk height move controller.
`timescale 1ns / 1ps

module dhmc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  dhmc_pkg::result_t   result,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output dhmc_pkg::result_t   m_result
);

    logic              valid_reg;
    logic              valid_next;
    dhmc_pkg::result_t result_reg;

    assign advance  = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

endmodule
